// File: sv/mclb_pkg.sv
// Shared types and constants for the multi-channel LED blinker.
// Used by mclb_chan_unit and multi_channel_led_blinker_unit; no dependencies.

package mclb_pkg;

    // default sizing
    localparam int CHANNELS_DEF  = 16;
    localparam int TIME_BITS_DEF = 16;

    // width of the channel masks and of the pin word
    localparam int MASK_BITS = 16;

    // cycle target code that means flash forever
    localparam logic [15:0] FOREVER_MARK = 16'hFFFF;

    // command codes
    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_START     = 3'd1,
        CMD_STOP      = 3'd2,
        CMD_FORCE_ON  = 3'd3,
        CMD_FORCE_OFF = 3'd4,
        CMD_QUERY     = 3'd5
    } cmd_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_REGISTERED = 1'b0,
        CFG_POLARITY   = 1'b1
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_RUN,
        ST_RESULT
    } state_t;

    // control handed to the channel update unit
    typedef struct packed {
        cmd_t cmd;
        logic reg_ok;
    } ctrl_t;

endpackage

// File: sv/multi_channel_led_blinker_unit.sv
// Multi-channel LED blinker: command input, result output, channel state memory.
// Depends on mclb_pkg and mclb_chan_unit.
//
// Usage:
//   Configuration words (cfg_index 0 registered mask, 1 polarity mask) are
//   written with cfg_valid/cfg_ready; cfg_ready is always high and writes
//   are meant for idle periods only.
//   Command words enter on in_valid/in_stall and each gives exactly one
//   result word (pin_levels, flash_done) on out_valid/out_stall.
//   One channel record is read from the state memory and updated per cycle
//   by the shared update unit, with the next read overlapped.
//   After accept, a tick or an all-channels command passes the fetch state,
//   the run state, which updates every channel in turn, and the result
//   state; a single-channel command or query updates only its channel, and
//   an ignored command goes straight to the result state. in_stall stays
//   high from accept until the result is loaded into the output register.
//   Reset clears all channel state (per-entry valid bits), turns all lamps
//   off, clears the registered mask and sets the polarity mask to all ones.
//   While the receiver stalls, the result word holds; a following command
//   may be accepted and run, and its result waits until the output frees.

module multi_channel_led_blinker_unit #(
    parameter int CHANNELS  = mclb_pkg::CHANNELS_DEF,
    parameter int TIME_BITS = mclb_pkg::TIME_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [3:0]  channel,
    input  logic        all_channels,
    input  logic [15:0] on_ticks,
    input  logic [15:0] off_ticks,
    input  logic [15:0] cycle_target,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] pin_levels,
    output logic        flash_done
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int REC_W = 3 * TIME_BITS + 34;

    // control registers
    mclb_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             sweep_reg, sweep_next;
    logic             out_valid_reg, out_valid_next;
    logic [15:0]      registered_reg;
    logic [15:0]      polarity_reg;
    logic [CHANNELS-1:0] lamp_reg, lamp_next;
    logic [CHANNELS-1:0] valid_reg;
    logic             rd_valid_reg;

    // payload registers
    mclb_pkg::cmd_t   cmd_reg, cmd_next;
    logic [15:0]      on_ticks_reg, off_ticks_reg, target_reg;
    logic             done_reg, done_next;
    logic [15:0]      pin_levels_reg, pin_levels_next;
    logic             flash_done_reg, flash_done_next;
    logic [REC_W-1:0] rd_data_reg;

    // memory
    logic [REC_W-1:0] mem [CHANNELS];
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [REC_W-1:0] wr_data;
    logic [REC_W-1:0] rec_rd;

    // accept decode
    mclb_pkg::cmd_t   cmd_in;
    logic             accept;
    logic             ch_ok;
    logic             go_sweep, go_single;
    logic             last;
    logic [15:0]      lamp16;

    // unit connections
    mclb_pkg::ctrl_t      ctrl;
    logic                 r_lit, r_en, u_lit, u_en, u_lamp, u_done;
    logic [TIME_BITS-1:0] r_phase, r_on, r_off, u_phase, u_on, u_off;
    logic [15:0]          r_cyc, r_tgt, u_cyc, u_tgt;

    assign cfg_ready  = 1'b1;
    assign in_stall   = (state_reg != mclb_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign pin_levels = pin_levels_reg;
    assign flash_done = flash_done_reg;

    assign accept = in_valid && !in_stall;
    assign cmd_in = mclb_pkg::cmd_t'(cmd);
    assign ch_ok  = (32'(channel) < CHANNELS);

    // decide how a new command word is processed
    always_comb
    begin
        go_sweep  = 1'b0;
        go_single = 1'b0;
        case (cmd_in)
            mclb_pkg::CMD_TICK:
            begin
                go_sweep = 1'b1;
            end
            mclb_pkg::CMD_START, mclb_pkg::CMD_STOP,
            mclb_pkg::CMD_FORCE_ON, mclb_pkg::CMD_FORCE_OFF:
            begin
                if (!((cmd_in == mclb_pkg::CMD_START) && (on_ticks == 16'd0)))
                begin
                    go_sweep  = all_channels;
                    go_single = !all_channels && ch_ok;
                end
            end
            mclb_pkg::CMD_QUERY:
            begin
                go_single = ch_ok;
            end
            default:
            begin
            end
        endcase
    end

    // channel record read side: unwritten entries read as reset value
    assign rec_rd = rd_valid_reg ? rd_data_reg : '0;
    assign {r_lit, r_en, r_phase, r_cyc, r_on, r_off, r_tgt} = rec_rd;
    assign wr_data = {u_lit, u_en, u_phase, u_cyc, u_on, u_off, u_tgt};

    assign ctrl.cmd    = cmd_reg;
    assign ctrl.reg_ok = (32'(idx_reg) < mclb_pkg::MASK_BITS) && registered_reg[4'(idx_reg)];

    assign last = sweep_reg ? (32'(idx_reg) == CHANNELS - 1) : 1'b1;

    mclb_chan_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_chan (
        .ctrl         (ctrl),
        .on_ticks     (on_ticks_reg),
        .off_ticks    (off_ticks_reg),
        .cycle_target (target_reg),
        .lit_in       (r_lit),
        .en_in        (r_en),
        .lamp_in      (lamp_reg[idx_reg]),
        .phase_in     (r_phase),
        .on_in        (r_on),
        .off_in       (r_off),
        .cyc_in       (r_cyc),
        .tgt_in       (r_tgt),
        .lit_out      (u_lit),
        .en_out       (u_en),
        .lamp_out     (u_lamp),
        .phase_out    (u_phase),
        .on_out       (u_on),
        .off_out      (u_off),
        .cyc_out      (u_cyc),
        .tgt_out      (u_tgt),
        .done         (u_done)
    );

    // pin levels follow polarity; channels beyond the bank read as lamp off
    assign lamp16 = 16'(lamp_reg);

    // sequencer next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        sweep_next      = sweep_reg;
        cmd_next        = cmd_reg;
        done_next       = done_reg;
        lamp_next       = lamp_reg;
        out_valid_next  = out_valid_reg && out_stall;
        pin_levels_next = pin_levels_reg;
        flash_done_next = flash_done_reg;
        rd_addr         = idx_reg;
        mem_we          = 1'b0;
        case (state_reg)
            mclb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd_in;
                    sweep_next = go_sweep;
                    done_next  = 1'b0;
                    idx_next   = go_sweep ? '0 : IDX_W'(channel);
                    state_next = (go_sweep || go_single) ? mclb_pkg::ST_FETCH
                                                         : mclb_pkg::ST_RESULT;
                end
            end
            mclb_pkg::ST_FETCH:
            begin
                state_next = mclb_pkg::ST_RUN;
            end
            mclb_pkg::ST_RUN:
            begin
                // update current channel, prefetch the next one
                rd_addr = last ? idx_reg : idx_reg + 1'b1;
                if (cmd_reg == mclb_pkg::CMD_QUERY)
                begin
                    done_next = u_done;
                end
                else
                begin
                    mem_we             = 1'b1;
                    lamp_next[idx_reg] = u_lamp;
                end
                if (last)
                begin
                    state_next = mclb_pkg::ST_RESULT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            mclb_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    pin_levels_next = ~(lamp16 ^ polarity_reg);
                    flash_done_next = done_reg;
                    state_next      = mclb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mclb_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mclb_pkg::ST_IDLE;
            idx_reg        <= '0;
            sweep_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            registered_reg <= 16'h0000;
            polarity_reg   <= 16'hFFFF;
            lamp_reg       <= '0;
            valid_reg      <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
            lamp_reg      <= lamp_next;
            rd_valid_reg  <= valid_reg[rd_addr];
            if (mem_we)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (mclb_pkg::cfg_reg_t'(cfg_index))
                    mclb_pkg::CFG_REGISTERED: registered_reg <= cfg_data;
                    mclb_pkg::CFG_POLARITY:   polarity_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        done_reg       <= done_next;
        pin_levels_reg <= pin_levels_next;
        flash_done_reg <= flash_done_next;
        if (accept)
        begin
            on_ticks_reg  <= on_ticks;
            off_ticks_reg <= off_ticks;
            target_reg    <= cycle_target;
        end
    end

    // channel state memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

`ifndef SYNTHESIS
    // a result word only appears after the result state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == mclb_pkg::ST_RESULT))
        else $error("result word without result state");

    // the sweep index stays inside the bank while updating
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mclb_pkg::ST_RUN) |-> (32'(idx_reg) < CHANNELS))
        else $error("channel index out of range");

    // an accepted command always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != mclb_pkg::ST_IDLE))
        else $error("accepted command not processed");

    // a single-channel command finishes after one update
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mclb_pkg::ST_RUN && !sweep_reg) |=>
            (state_reg == mclb_pkg::ST_RESULT))
        else $error("single-channel command did not finish");

    // the memory is written only by the update step
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == mclb_pkg::ST_RUN && cmd_reg != mclb_pkg::CMD_QUERY))
        else $error("unexpected state memory write");
`endif

endmodule

// File: sv/mclb_chan_unit.sv
// Shared per-channel update unit: applies one command or one tick to one channel record.
// Depends on mclb_pkg.

module mclb_chan_unit #(
    parameter int TIME_BITS = mclb_pkg::TIME_BITS_DEF
) (
    input  mclb_pkg::ctrl_t        ctrl,
    input  logic [15:0]            on_ticks,
    input  logic [15:0]            off_ticks,
    input  logic [15:0]            cycle_target,
    input  logic                   lit_in,
    input  logic                   en_in,
    input  logic                   lamp_in,
    input  logic [TIME_BITS-1:0]   phase_in,
    input  logic [TIME_BITS-1:0]   on_in,
    input  logic [TIME_BITS-1:0]   off_in,
    input  logic [15:0]            cyc_in,
    input  logic [15:0]            tgt_in,
    output logic                   lit_out,
    output logic                   en_out,
    output logic                   lamp_out,
    output logic [TIME_BITS-1:0]   phase_out,
    output logic [TIME_BITS-1:0]   on_out,
    output logic [TIME_BITS-1:0]   off_out,
    output logic [15:0]            cyc_out,
    output logic [15:0]            tgt_out,
    output logic                   done
);

    localparam logic [TIME_BITS-1:0] TMAX = '1;

    logic [TIME_BITS-1:0] bumped;
    logic [15:0]          cyc_bump;
    logic                 counted;

    // saturating counters and target test
    assign bumped   = (phase_in == TMAX) ? phase_in : phase_in + 1'b1;
    assign cyc_bump = (cyc_in == 16'hFFFF) ? cyc_in : cyc_in + 16'd1;
    assign counted  = (tgt_in != 16'd0) && (tgt_in != mclb_pkg::FOREVER_MARK);
    assign done     = (cyc_in >= tgt_in);

    // next record
    always_comb
    begin
        lit_out   = lit_in;
        en_out    = en_in;
        lamp_out  = lamp_in;
        phase_out = phase_in;
        on_out    = on_in;
        off_out   = off_in;
        cyc_out   = cyc_in;
        tgt_out   = tgt_in;
        if (ctrl.reg_ok)
        begin
            case (ctrl.cmd)
                mclb_pkg::CMD_TICK:
                begin
                    if (en_in && (off_in != '0))
                    begin
                        phase_out = bumped;
                        if (lit_in)
                        begin
                            // end of the lit phase
                            if (bumped >= on_in)
                            begin
                                lamp_out  = 1'b0;
                                phase_out = '0;
                                lit_out   = 1'b0;
                            end
                        end
                        else if (bumped >= off_in)
                        begin
                            // end of the dark phase: one cycle finished
                            if (counted && (cyc_bump >= tgt_in))
                            begin
                                cyc_out = cyc_bump;
                                en_out  = 1'b0;
                                off_out = '0;
                            end
                            else
                            begin
                                if (counted)
                                begin
                                    cyc_out = cyc_bump;
                                end
                                phase_out = '0;
                                lit_out   = 1'b1;
                                lamp_out  = 1'b1;
                            end
                        end
                    end
                end
                mclb_pkg::CMD_START:
                begin
                    on_out    = TIME_BITS'(on_ticks);
                    off_out   = TIME_BITS'(off_ticks);
                    tgt_out   = cycle_target;
                    phase_out = '0;
                    lit_out   = 1'b1;
                    cyc_out   = 16'd0;
                    en_out    = 1'b1;
                    lamp_out  = 1'b1;
                end
                mclb_pkg::CMD_STOP:
                begin
                    on_out    = '0;
                    off_out   = '0;
                    phase_out = '0;
                    en_out    = 1'b0;
                    tgt_out   = 16'd0;
                    cyc_out   = 16'd0;
                    lamp_out  = 1'b0;
                end
                mclb_pkg::CMD_FORCE_ON:
                begin
                    lamp_out = 1'b1;
                end
                mclb_pkg::CMD_FORCE_OFF:
                begin
                    lamp_out = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
